@@ sv/dsa_pkg.sv @@
`timescale 1ns / 1ps
// dsa_pkg: shared types, constants and helpers for decimal_scale_align.
// No dependencies; used by dsa_ctrl, dsa_datapath and decimal_scale_align.
package dsa_pkg;

  localparam int MagBitsDefault  = 96;
  localparam int MaxScaleDefault = 28;

  localparam int FieldMagW = 96;
  localparam int MagLoW    = 64;
  localparam int MagHiW    = 32;
  localparam int MagMinW   = 32;
  localparam int ScaleW    = 5;

  // divide by ten works on 24-bit chunks, most significant first
  localparam int ChunkW     = 24;
  localparam int RemW       = 4;
  localparam int RecipW     = 29;
  localparam int RecipShift = 32;
  localparam logic [RecipW-1:0] Recip10 = 29'd429496730;

  typedef struct packed {
    logic [MagLoW-1:0] a_mag_low;
    logic [MagHiW-1:0] a_mag_high;
    logic [ScaleW-1:0] a_scale;
    logic              a_negative;
    logic [MagLoW-1:0] b_mag_low;
    logic [MagHiW-1:0] b_mag_high;
    logic [ScaleW-1:0] b_scale;
    logic              b_negative;
  } req_t;

  typedef struct packed {
    logic [MagLoW-1:0] out_a_low;
    logic [MagHiW-1:0] out_a_high;
    logic [MagLoW-1:0] out_b_low;
    logic [MagHiW-1:0] out_b_high;
    logic [ScaleW-1:0] common_scale;
    logic              out_a_negative;
    logic              out_b_negative;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_chunk;
    logic dec_high;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scales_eq;
    logic fits;
  } sts_t;

  function automatic int mag_width(input int bits);
    int w;
    w = bits;
    if (w > FieldMagW) w = FieldMagW;
    if (w < MagMinW) w = MagMinW;
    return w;
  endfunction

  function automatic int chunk_count(input int bits);
    return (mag_width(bits) + ChunkW - 1) / ChunkW;
  endfunction

endpackage

@@ sv/decimal_scale_align.sv @@
`timescale 1ns / 1ps
// decimal_scale_align: brings two scaled 96-bit decimals to a common scale.
// Steps: the lower-scale operand is multiplied by ten while it fits, then the higher-scale
// one is divided by ten, in C = ceil(width/24) chunks (4 at 96) per step, until scales match.
// Flow control: one request in flight; a new one is accepted once the result is loaded,
// and loading waits while the previous result is still stalled.
// Synchronous reset clears the sequencer and the result valid; no clearing pass.
module decimal_scale_align #(
  parameter int MAG_BITS  = dsa_pkg::MagBitsDefault,
  parameter int MAX_SCALE = dsa_pkg::MaxScaleDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dsa_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output dsa_pkg::res_t res
);
  import dsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dsa_ctrl #(
    .MAG_BITS(MAG_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsa_datapath #(
    .MAG_BITS (MAG_BITS),
    .MAX_SCALE(MAX_SCALE)
  ) u_datapath (
    .clk(clk),
    .req(req),
    .cmd(cmd),
    .sts(sts),
    .res(res)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted but block not busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result appeared without a request in flight");

  a_scale_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (int'(res.common_scale) <= MAX_SCALE))
    else $error("common scale above maximum");

endmodule

@@ sv/dsa_ctrl.sv @@
`timescale 1ns / 1ps
// dsa_ctrl: sequencer for decimal_scale_align (load, x10 steps, /10 chunks, result).
// Depends on dsa_pkg.
module dsa_ctrl #(
  parameter int MAG_BITS = dsa_pkg::MagBitsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          res_valid,
  input  logic          res_stall,
  input  dsa_pkg::sts_t sts,
  output dsa_pkg::cmd_t cmd
);
  import dsa_pkg::*;

  localparam int Chunks = chunk_count(MAG_BITS);
  localparam int CntW   = $clog2(Chunks);
  localparam logic [CntW-1:0] LastChunk = CntW'(Chunks - 1);

  state_t          state, state_next;
  logic [CntW-1:0] cnt, cnt_next;
  logic            out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sts.scales_eq) begin
          state_next = ST_FINISH;
        end else if (sts.fits) begin
          cmd.mul_step = 1'b1;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.scales_eq) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_chunk = 1'b1;
          if (cnt == LastChunk) begin
            cmd.dec_high = 1'b1;
            cnt_next     = '0;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid || !res_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !res_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign req_stall = (state != ST_IDLE);
  assign res_valid = out_valid;

endmodule

@@ sv/dsa_datapath.sv @@
`timescale 1ns / 1ps
// dsa_datapath: magnitude and scale registers, x10 adder, chunked /10 unit,
// result register. Depends on dsa_pkg.
module dsa_datapath #(
  parameter int MAG_BITS  = dsa_pkg::MagBitsDefault,
  parameter int MAX_SCALE = dsa_pkg::MaxScaleDefault
) (
  input  logic          clk,
  input  dsa_pkg::req_t req,
  input  dsa_pkg::cmd_t cmd,
  output dsa_pkg::sts_t sts,
  output dsa_pkg::res_t res
);
  import dsa_pkg::*;

  localparam int MagW   = mag_width(MAG_BITS);
  localparam int Chunks = chunk_count(MAG_BITS);
  localparam int PadW   = Chunks * ChunkW;
  localparam int VW     = RemW + ChunkW;
  localparam int ProdW  = VW + RecipW;

  logic [MagW-1:0]      low_mag;
  logic [PadW-1:0]      high_mag;
  logic [ScaleW-1:0]    lo_exp, hi_exp;
  logic                 low_is_a;
  logic                 a_neg, b_neg;
  logic [RemW-1:0]      rem;
  res_t                 res_q;

  logic [FieldMagW-1:0] a_full, b_full;
  logic [MagW-1:0]      a_trim, b_trim;
  logic [ScaleW-1:0]    sa, sb;
  logic [MagW+3:0]      times_ten;
  logic [VW-1:0]        div_v;
  logic [ProdW-1:0]     div_prod;
  logic [ChunkW-1:0]    div_q;
  logic [RemW-1:0]      q_ten_lo;
  logic [RemW-1:0]      rem_next;
  logic [FieldMagW-1:0] a_out, b_out;
  logic [MagW-1:0]      high_trim;

  assign a_full = {req.a_mag_high, req.a_mag_low};
  assign b_full = {req.b_mag_high, req.b_mag_low};
  assign a_trim = a_full[MagW-1:0];
  assign b_trim = b_full[MagW-1:0];
  assign sa = (int'(req.a_scale) > MAX_SCALE) ? ScaleW'(MAX_SCALE) : req.a_scale;
  assign sb = (int'(req.b_scale) > MAX_SCALE) ? ScaleW'(MAX_SCALE) : req.b_scale;

  // x*2 + x*8
  assign times_ten = ({4'b0000, low_mag} << 1) + ({4'b0000, low_mag} << 3);

  // one chunk of long division by ten via reciprocal
  assign div_v    = {rem, high_mag[PadW-1 -: ChunkW]};
  assign div_prod = ProdW'(div_v) * ProdW'(Recip10);
  assign div_q    = div_prod[RecipShift +: ChunkW];
  assign q_ten_lo = {div_q[2:0], 1'b0} + {div_q[0], 3'b000};
  assign rem_next = div_v[RemW-1:0] - q_ten_lo;

  assign sts.scales_eq = (lo_exp == hi_exp);
  assign sts.fits      = (times_ten[MagW+3:MagW] == 4'b0000);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      low_is_a <= (sa < sb);
      low_mag  <= (sa < sb) ? a_trim : b_trim;
      high_mag <= PadW'((sa < sb) ? b_trim : a_trim);
      lo_exp   <= (sa < sb) ? sa : sb;
      hi_exp   <= (sa < sb) ? sb : sa;
      a_neg    <= req.a_negative;
      b_neg    <= req.b_negative;
      rem      <= '0;
    end else begin
      if (cmd.mul_step) begin
        low_mag <= times_ten[MagW-1:0];
        lo_exp  <= lo_exp + 1'b1;
      end
      if (cmd.div_chunk) begin
        high_mag <= {high_mag[PadW-ChunkW-1:0], div_q};
        rem      <= cmd.dec_high ? '0 : rem_next;
      end
      if (cmd.dec_high) begin
        hi_exp <= hi_exp - 1'b1;
      end
    end
  end

  assign high_trim = high_mag[MagW-1:0];
  assign a_out = FieldMagW'(low_is_a ? low_mag : high_trim);
  assign b_out = FieldMagW'(low_is_a ? high_trim : low_mag);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_q.out_a_low      <= a_out[MagLoW-1:0];
      res_q.out_a_high     <= a_out[FieldMagW-1:MagLoW];
      res_q.out_b_low      <= b_out[MagLoW-1:0];
      res_q.out_b_high     <= b_out[FieldMagW-1:MagLoW];
      res_q.common_scale   <= lo_exp;
      res_q.out_a_negative <= a_neg;
      res_q.out_b_negative <= b_neg;
    end
  end

  assign res = res_q;

endmodule
